// File: hdl/idr_pkg.sv
// ----------------------------------------------------------------------------
// Inertial dead reckoning package
// Widths, register codes, payload beats and sequencer types.
// ----------------------------------------------------------------------------
package idr_pkg;

  localparam int WORD_W      = 16;
  localparam int ACC_W       = 32;
  localparam int TICKS_W     = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_AXES    = 3;
  localparam int IDR_AXES    = 3;
  localparam int ASR_SHIFT   = 4;

  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_DIGITS  = WORD_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
  localparam int MUL_HI_W    = WORD_W + MUL_DIGIT_W + 1;

  localparam logic [WORD_W-1:0]  ACCEL_GAIN_RST      = 16'd304;
  localparam logic [WORD_W-1:0]  VELOCITY_GAIN_RST   = 16'd262;
  localparam logic [WORD_W-1:0]  CORRECTION_GAIN_RST = 16'd1638;
  localparam logic [TICKS_W-1:0] CORRECTION_TICKS_RST = 8'd14;

  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_GAIN      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_GAIN   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_GAIN = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_TICKS = 4'd3;

  typedef struct packed {
    logic              enable;
    logic              fix_request;
    logic [WORD_W-1:0] accel_x;
    logic [WORD_W-1:0] accel_y;
    logic [WORD_W-1:0] accel_z;
    logic [WORD_W-1:0] gps_loc_x;
    logic [WORD_W-1:0] gps_loc_y;
    logic [WORD_W-1:0] gps_loc_z;
    logic [WORD_W-1:0] gps_vel_x;
    logic [WORD_W-1:0] gps_vel_y;
    logic [WORD_W-1:0] gps_vel_z;
  } idr_in_t;

  typedef struct packed {
    logic [ACC_W-1:0] velocity_x;
    logic [ACC_W-1:0] velocity_y;
    logic [ACC_W-1:0] velocity_z;
    logic [ACC_W-1:0] location_x;
    logic [ACC_W-1:0] location_y;
    logic [ACC_W-1:0] location_z;
    logic             fix_consumed;
    logic             clear_yaw_error;
  } idr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_CAPTURE,
    ST_DONE
  } idr_state_t;

  typedef enum logic [1:0] {
    OP_ACCEL,
    OP_VEL,
    OP_VERR,
    OP_LERR
  } idr_op_t;

endpackage

// File: hdl/idr_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial signed multiplier
// 16 x 16 signed product, one 4-bit digit of b per cycle, shift-add form.
// ----------------------------------------------------------------------------
module idr_mul import idr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [ACC_W-1:0]  product
);

  logic                        busy;
  logic [MUL_CNT_W-1:0]        cnt;
  logic signed [WORD_W-1:0]    a_q;
  logic [WORD_W-1:0]           b_sh;
  logic signed [MUL_HI_W-1:0]  hi;
  logic [WORD_W-1:0]           lo;
  logic                        last;
  logic signed [MUL_DIGIT_W:0] digit;
  logic signed [MUL_HI_W-1:0]  pp;
  logic signed [MUL_HI_W-1:0]  sum;

  assign last = (cnt == MUL_CNT_W'(MUL_DIGITS - 1));

  always_comb begin
    if (last) begin
      digit = {b_sh[MUL_DIGIT_W-1], b_sh[MUL_DIGIT_W-1:0]};
    end else begin
      digit = {1'b0, b_sh[MUL_DIGIT_W-1:0]};
    end
    pp  = a_q * digit;
    sum = hi + pp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_sh <= b;
      hi   <= '0;
      lo   <= '0;
    end else if (busy) begin
      b_sh <= b_sh >> MUL_DIGIT_W;
      lo   <= {sum[MUL_DIGIT_W-1:0], lo[WORD_W-1:MUL_DIGIT_W]};
      hi   <= sum >>> MUL_DIGIT_W;
    end
  end

  assign product = {hi[WORD_W-1:0], lo};

endmodule

// File: hdl/inertial_dead_reckoning.sv
// ----------------------------------------------------------------------------
// Inertial dead reckoning
// Velocity and location integration with GPS error correction.
// ----------------------------------------------------------------------------
// One sample beat in, one result beat out. A sample is taken when
// sample_valid and sample_ready are high; the result appears on result with
// result_valid and stays until result_ready. Gains and the correction length
// are written on the cfg channel (always ready); the user must write them
// only while the block is idle: the block itself does not enforce it. All
// products go through one shared 16 x 16 multiplier that retires one 4-bit
// digit per cycle; a product is loaded, takes four digits, then is accumulated.
// An enabled sample needs two products per axis, four while the correction
// countdown runs, then ST_CAPTURE, then ST_DONE, which loads the result. A
// disabled sample clears the accumulators and goes straight to ST_DONE. The
// result register frees the input side: a new sample is taken while the last
// result waits, and the block holds the next result in its final state until
// the receiver drains the register.
// Reset clears accumulators, errors and result_valid, and restores the
// register defaults; the countdown restarts at its reset length.
// ----------------------------------------------------------------------------
module inertial_dead_reckoning import idr_pkg::*; #(
  parameter int AXES = IDR_AXES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  idr_in_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output idr_out_t               result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  idr_state_t          state;
  idr_state_t          state_next;
  idr_op_t             op;
  idr_op_t             op_next;
  logic [AXIS_W-1:0]   axis;
  idr_in_t             smp;

  logic [WORD_W-1:0]   accel_gain;
  logic [WORD_W-1:0]   velocity_gain;
  logic [WORD_W-1:0]   correction_gain;
  logic [TICKS_W-1:0]  correction_ticks;
  logic [TICKS_W-1:0]  countdown;

  logic [ACC_W-1:0]    vel  [AXES];
  logic [ACC_W-1:0]    loc  [AXES];
  logic [WORD_W-1:0]   verr [AXES];
  logic [WORD_W-1:0]   lerr [AXES];
  logic                fix_flag;
  logic                yaw_flag;

  logic [WORD_W-1:0]   s_accel [MAX_AXES];
  logic [WORD_W-1:0]   s_gloc  [MAX_AXES];
  logic [WORD_W-1:0]   s_gvel  [MAX_AXES];
  logic [ACC_W-1:0]    vel3    [MAX_AXES];
  logic [ACC_W-1:0]    loc3    [MAX_AXES];

  logic                accept;
  logic                mul_start;
  logic                mul_done;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [ACC_W-1:0]    mul_p;
  logic                op_last;
  logic                result_load;
  logic [ACC_W-1:0]    vel_sum;
  logic [ACC_W-1:0]    loc_sum;
  logic [ACC_W-1:0]    loc_inc;
  idr_out_t            result_next;

  assign s_accel[0] = smp.accel_x;
  assign s_accel[1] = smp.accel_y;
  assign s_accel[2] = smp.accel_z;
  assign s_gloc[0]  = smp.gps_loc_x;
  assign s_gloc[1]  = smp.gps_loc_y;
  assign s_gloc[2]  = smp.gps_loc_z;
  assign s_gvel[0]  = smp.gps_vel_x;
  assign s_gvel[1]  = smp.gps_vel_y;
  assign s_gvel[2]  = smp.gps_vel_z;

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
    if (g < AXES) begin : g_used
      assign vel3[g] = vel[g];
      assign loc3[g] = loc[g];
    end else begin : g_unused
      assign vel3[g] = '0;
      assign loc3[g] = '0;
    end
  end

  assign cfg_ready = 1'b1;
  assign accept    = sample_valid && sample_ready;
  assign op_last   = (op == OP_LERR) || ((op == OP_VEL) && (countdown == '0));

  always_comb begin
    unique case (op)
      OP_ACCEL: begin
        mul_a = accel_gain;
        mul_b = s_accel[axis];
      end
      OP_VEL: begin
        mul_a = velocity_gain;
        mul_b = vel[axis][ACC_W-1:WORD_W];
      end
      OP_VERR: begin
        mul_a = correction_gain;
        mul_b = verr[axis];
      end
      OP_LERR: begin
        mul_a = correction_gain;
        mul_b = lerr[axis];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  idr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    if (op == OP_VEL) begin
      loc_inc = {{ASR_SHIFT{mul_p[ACC_W-1]}}, mul_p[ACC_W-1:ASR_SHIFT]};
    end else begin
      loc_inc = mul_p;
    end
    vel_sum = vel[axis] + mul_p;
    loc_sum = loc[axis] + loc_inc;
  end

  always_comb begin
    unique case (op)
      OP_ACCEL: op_next = OP_VEL;
      OP_VEL:   op_next = OP_VERR;
      OP_VERR:  op_next = OP_LERR;
      OP_LERR:  op_next = OP_ACCEL;
      default:  op_next = OP_ACCEL;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = sample.enable ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (op_last && (axis == LAST_AXIS)) begin
            state_next = ST_CAPTURE;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_CAPTURE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_ready = (state == ST_IDLE);
    mul_start    = (state == ST_LOAD);
    result_load  = (state == ST_DONE) && (!result_valid || result_ready);
  end

  always_comb begin
    result_next.velocity_x      = vel3[0];
    result_next.velocity_y      = vel3[1];
    result_next.velocity_z      = vel3[2];
    result_next.location_x      = loc3[0];
    result_next.location_y      = loc3[1];
    result_next.location_z      = loc3[2];
    result_next.fix_consumed    = fix_flag;
    result_next.clear_yaw_error = yaw_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      op               <= OP_ACCEL;
      axis             <= '0;
      result_valid     <= 1'b0;
      fix_flag         <= 1'b0;
      yaw_flag         <= 1'b0;
      accel_gain       <= ACCEL_GAIN_RST;
      velocity_gain    <= VELOCITY_GAIN_RST;
      correction_gain  <= CORRECTION_GAIN_RST;
      correction_ticks <= CORRECTION_TICKS_RST;
      countdown        <= CORRECTION_TICKS_RST;
      for (int i = 0; i < AXES; i++) begin
        vel[i]  <= '0;
        loc[i]  <= '0;
        verr[i] <= '0;
        lerr[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL_GAIN:       accel_gain       <= cfg_data;
          REG_VELOCITY_GAIN:    velocity_gain    <= cfg_data;
          REG_CORRECTION_GAIN:  correction_gain  <= cfg_data;
          REG_CORRECTION_TICKS: correction_ticks <= cfg_data[TICKS_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        axis     <= '0;
        op       <= OP_ACCEL;
        fix_flag <= 1'b0;
        yaw_flag <= 1'b0;
        if (!sample.enable) begin
          for (int i = 0; i < AXES; i++) begin
            vel[i] <= '0;
            loc[i] <= '0;
          end
        end
      end

      if ((state == ST_MUL) && mul_done) begin
        if ((op == OP_ACCEL) || (op == OP_VERR)) begin
          vel[axis] <= vel_sum;
        end else begin
          loc[axis] <= loc_sum;
        end
        if (op_last) begin
          op   <= OP_ACCEL;
          axis <= axis + AXIS_W'(1);
        end else begin
          op <= op_next;
        end
      end

      if (state == ST_CAPTURE) begin
        yaw_flag <= (countdown == '0);
        if (smp.fix_request) begin
          fix_flag  <= 1'b1;
          countdown <= correction_ticks;
          for (int i = 0; i < AXES; i++) begin
            lerr[i] <= s_gloc[i] - loc[i][ACC_W-1:WORD_W];
            verr[i] <= s_gvel[i] - vel[i][ACC_W-1:WORD_W];
          end
        end else if (countdown != '0) begin
          countdown <= countdown - TICKS_W'(1);
        end
      end

      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample;
    end
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule

// File: hdl/idr_chk.sv
// ----------------------------------------------------------------------------
// Inertial dead reckoning port checker
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module idr_chk import idr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input idr_out_t               result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample taken while one is in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_ready))
    else $error("result beat appeared without a sample in progress");

endmodule

bind inertial_dead_reckoning idr_chk u_idr_chk (.*);
